>>> design/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam int unsigned PIPE_DEPTH = 7;

    // Reciprocal multipliers for division by constants
    localparam logic [26:0] DAY_MUL   = 27'd101806633; // (secs >> 7) / 675
    localparam logic [17:0] HOUR_MUL  = 18'd149131;    // rem / 3600, shift 29
    localparam logic [12:0] MIN_MUL   = 13'd4370;      // r / 60, shift 18
    localparam logic [16:0] QUAD_MUL  = 17'd91868;     // e / 1461, shift 27
    localparam logic [16:0] WEEK_MUL  = 17'd74899;     // v / 7, shift 19

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    // Day count is rebased to 1968-01-01, a leap year
    localparam logic [15:0] BASE_OFFSET  = 16'd731;
    // First day after the missing 2100-02-29
    localparam logic [15:0] SKIP_LEAP_DAY = 16'd47541;
    localparam logic [11:0] BASE_YEAR    = 12'd1968;
    // 1970-01-01 was a Thursday
    localparam logic [15:0] WEEKDAY_OFFSET = 16'd4;

    localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
    } date_t;

endpackage

>>> design/ecal_in_if.sv
// ----------------------------------------------------------------------------
// ecal_in_if
// Input channel: one epoch seconds count per beat.
// ----------------------------------------------------------------------------
interface ecal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

>>> design/ecal_out_if.sv
// ----------------------------------------------------------------------------
// ecal_out_if
// Output channel: one calendar date and time per beat.
// ----------------------------------------------------------------------------
interface ecal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

>>> design/ecal_daysplit.sv
// ----------------------------------------------------------------------------
// ecal_daysplit
// Two stages: whole days from the seconds count by reciprocal multiply.
// ----------------------------------------------------------------------------
module ecal_daysplit (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] secs,
    output logic [15:0] days,
    output logic [31:0] secs_out
);
    import ecal_pkg::*;

    logic [51:0] prod_reg;
    logic [51:0] prod_next;
    logic [31:0] secs1_reg;
    logic [15:0] days_reg;
    logic [15:0] days_next;
    logic [31:0] secs2_reg;

    // Divide by 86400 as (secs >> 7) / 675
    assign prod_next = {27'd0, secs[31:7]} * {25'd0, DAY_MUL};
    assign days_next = prod_reg[51:36];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            secs1_reg <= secs;
            days_reg  <= days_next;
            secs2_reg <= secs1_reg;
        end
    end

    assign days     = days_reg;
    assign secs_out = secs2_reg;
endmodule

>>> design/ecal_clock.sv
// ----------------------------------------------------------------------------
// ecal_clock
// Five stages: hour, minute and second from the seconds within the day.
// ----------------------------------------------------------------------------
module ecal_clock (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        secs,
    input  logic [15:0]        days,
    output ecal_pkg::tod_t     tod
);
    import ecal_pkg::*;

    logic [31:0] day_secs;
    logic [16:0] rem_next;
    logic [16:0] rem3_reg;
    logic [16:0] rem4_reg;
    logic [34:0] ph_reg;
    logic [4:0]  hour_next;
    logic [11:0] r2_next;
    logic [4:0]  hour5_reg;
    logic [4:0]  hour6_reg;
    logic [11:0] r5_reg;
    logic [11:0] r6_reg;
    logic [24:0] pm_reg;
    logic [5:0]  minute_next;
    logic [5:0]  second_next;
    tod_t        tod_reg;

    // Seconds within the day
    assign day_secs = secs - 32'({16'd0, days} * {15'd0, SECS_PER_DAY});
    assign rem_next = day_secs[16:0];

    // Split off the hour
    assign hour_next = ph_reg[33:29];
    assign r2_next   = 12'(rem4_reg - 17'({12'd0, hour_next} * {5'd0, SECS_PER_HOUR}));

    // Split minute and second
    assign minute_next = pm_reg[23:18];
    assign second_next = 6'(r6_reg - 12'({6'd0, minute_next} * SECS_PER_MIN));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem3_reg  <= rem_next;
            rem4_reg  <= rem3_reg;
            ph_reg    <= {18'd0, rem3_reg} * {17'd0, HOUR_MUL};
            hour5_reg <= hour_next;
            r5_reg    <= r2_next;
            hour6_reg <= hour5_reg;
            r6_reg    <= r5_reg;
            pm_reg    <= {13'd0, r5_reg} * {12'd0, MIN_MUL};
            tod_reg   <= '{hour: hour6_reg, minute: minute_next, second: second_next};
        end
    end

    assign tod = tod_reg;
endmodule

>>> design/ecal_date.sv
// ----------------------------------------------------------------------------
// ecal_date
// Five stages: year, month, day of month and weekday from the day count.
// ----------------------------------------------------------------------------
module ecal_date (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        days,
    output ecal_pkg::date_t    date
);
    import ecal_pkg::*;

    logic [15:0] e_next;
    logic [15:0] v_next;
    logic [15:0] e3_reg;
    logic [15:0] v3_reg;
    logic [32:0] pq_reg;
    logic [32:0] pw_reg;
    logic [15:0] e4_reg;
    logic [15:0] v4_reg;
    logic [5:0]  quad_next;
    logic [10:0] r_next;
    logic [2:0]  wd_next;
    logic [5:0]  quad5_reg;
    logic [10:0] r5_reg;
    logic [2:0]  wd5_reg;
    logic [1:0]  yi_next;
    logic [8:0]  doy_next;
    logic [5:0]  quad6_reg;
    logic [1:0]  yi6_reg;
    logic [8:0]  doy6_reg;
    logic [2:0]  wd6_reg;
    logic        leap;
    logic [3:0]  mon_idx;
    logic [8:0]  mon_start;
    logic [8:0]  start_m;
    date_t       date_next;
    date_t       date_reg;

    // Rebase to 1968 and insert a day for 2100-02-29 so every fourth year leaps
    assign e_next = days + BASE_OFFSET + ((days >= SKIP_LEAP_DAY) ? 16'd1 : 16'd0);
    assign v_next = days + WEEKDAY_OFFSET;

    // Quotient and remainder of the four-year cycle and the week
    assign quad_next = pq_reg[32:27];
    assign r_next    = 11'(e4_reg - 16'({10'd0, quad_next} * {5'd0, DAYS_PER_QUAD}));
    assign wd_next   = 3'(v4_reg - 16'(pw_reg[32:19] * DAYS_PER_WEEK));

    // Year within the cycle and day of year
    always_comb
    begin
        priority if (r5_reg < 11'd366)
        begin
            yi_next  = 2'd0;
            doy_next = r5_reg[8:0];
        end
        else if (r5_reg < 11'd731)
        begin
            yi_next  = 2'd1;
            doy_next = 9'(r5_reg - 11'd366);
        end
        else if (r5_reg < 11'd1096)
        begin
            yi_next  = 2'd2;
            doy_next = 9'(r5_reg - 11'd731);
        end
        else
        begin
            yi_next  = 2'd3;
            doy_next = 9'(r5_reg - 11'd1096);
        end
    end

    // Find the month by comparing against the month starts
    assign leap = (yi6_reg == 2'd0);
    always_comb
    begin
        mon_idx   = 4'd0;
        mon_start = 9'd0;
        start_m   = 9'd0;
        for (int m = 1; m < 12; m++)
        begin
            start_m = DAYS_BEFORE_MONTH[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
            if (doy6_reg >= start_m)
            begin
                mon_idx   = 4'(m);
                mon_start = start_m;
            end
        end
        date_next.year         = BASE_YEAR + {4'd0, quad6_reg, 2'b00} + {10'd0, yi6_reg};
        date_next.month        = mon_idx + 4'd1;
        date_next.day_of_month = 5'(doy6_reg - mon_start + 9'd1);
        date_next.weekday      = wd6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e3_reg    <= e_next;
            v3_reg    <= v_next;
            pq_reg    <= {17'd0, e3_reg} * {16'd0, QUAD_MUL};
            pw_reg    <= {17'd0, v3_reg} * {16'd0, WEEK_MUL};
            e4_reg    <= e3_reg;
            v4_reg    <= v3_reg;
            quad5_reg <= quad_next;
            r5_reg    <= r_next;
            wd5_reg   <= wd_next;
            quad6_reg <= quad5_reg;
            yi6_reg   <= yi_next;
            doy6_reg  <= doy_next;
            wd6_reg   <= wd5_reg;
            date_reg  <= date_next;
        end
    end

    assign date = date_reg;
endmodule

>>> design/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 to a calendar date and time.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload
//  req     | in  | epoch_seconds[31:0]
//  rsp     | out | year, month, day_of_month, hour, minute, second, weekday
//
//  Seven register stages; one beat enters per cycle while the output is not
//  stalled. Reciprocal multiplies for days, then hour and minute (with the
//  four-year cycle in parallel), are each followed by a register.
//  Reset clears only the stage valid bits.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
    input  logic   clk,
    input  logic   rst_n,
    ecal_in_if.sink     req,
    ecal_out_if.source  rsp
);
    import ecal_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  en;
    logic [15:0]           days;
    logic [31:0]           secs2;
    tod_t                  tod;
    date_t                 date;

    // Advance whenever the output slot is free or being drained
    assign en        = !vld_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = en;
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    ecal_daysplit u_daysplit (
        .clk      (clk),
        .en       (en),
        .secs     (req.epoch_seconds),
        .days     (days),
        .secs_out (secs2)
    );

    ecal_clock u_clock (
        .clk  (clk),
        .en   (en),
        .secs (secs2),
        .days (days),
        .tod  (tod)
    );

    ecal_date u_date (
        .clk  (clk),
        .en   (en),
        .days (days),
        .date (date)
    );

    // Drive the result beat
    assign rsp.valid        = vld_reg[PIPE_DEPTH-1];
    assign rsp.year         = date.year;
    assign rsp.month        = date.month;
    assign rsp.day_of_month = date.day_of_month;
    assign rsp.weekday      = date.weekday;
    assign rsp.hour         = tod.hour;
    assign rsp.minute       = tod.minute;
    assign rsp.second       = tod.second;
endmodule

>>> design/ecal_checker.sv
// ----------------------------------------------------------------------------
// ecal_checker
// Port-level checks for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
module ecal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday
);
    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(hour) && $stable(minute)
            && $stable(second) && $stable(weekday))
        else $error("stalled result changed");

    // Back-pressure only when the result is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // Date fields in calendar range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
            && month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6)
        else $error("date out of range");

    // Time fields in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time out of range");
endmodule

bind epoch_seconds_to_calendar_core ecal_checker u_ecal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .year         (rsp.year),
    .month        (rsp.month),
    .day_of_month (rsp.day_of_month),
    .hour         (rsp.hour),
    .minute       (rsp.minute),
    .second       (rsp.second),
    .weekday      (rsp.weekday)
);
